// ----- design/slgr_pkg.sv -----
package slgr_pkg;

    // geometry
    localparam int AXES = 3;
    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int MAX_FINE_STEPS = 4096;
    localparam int FC_W = $clog2(MAX_FINE_STEPS + 1);

    // k advance per fine step, 0.00425759 in Q0.32
    localparam logic [31:0] KSTEP_Q32 = 32'd18286210;

    // iterations of the shared sqrt and divide units
    localparam int ITER_STEPS = 32;
    localparam int IT_W = $clog2(ITER_STEPS);

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KZ      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMPLITUDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_COEF = 3'd6;

    // register reset values
    localparam logic [30:0] AMP_RESET   = 31'd67108864;
    localparam logic [23:0] STEP_RESET  = 24'd251658;
    localparam logic [6:0]  RATIO_RESET = 7'd4;
    localparam logic [23:0] COEF_RESET  = 24'd2380990;

    // magnitude of a signed word, -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

    function automatic logic [34:0] mag35(input logic signed [34:0] v);
        logic [34:0] u;
        u = v;
        return v[34] ? (~u + 35'd1) : u;
    endfunction

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        logic [33:0] u;
        u = v;
        return v[33] ? (~u + 34'd1) : u;
    endfunction

    // saturate a 34-bit signed value into 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

// ----- design/slew_limited_gradient_rewinder_core.sv -----
// slew limited gradient rewinder
//
// channels: input transfers carry op and the start vectors; op start loads
// the gradient and k-space position and arms a run, op tick runs up to
// max(1, oversample_ratio) fine steps and yields one result transfer
// (grad_x/y/z, last, overrun). a tick with no run armed yields nothing.
// configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, writes belong to idle periods.
//
// timing: one shared 32x32 multiplier, a 32-step square root unit and a
// 32-step divider serve every fine step under the sequencer below. a tick
// runs a setup, then per fine step the norm and stopping point prediction
// and either a ramp-down step or a steering step (two vector clips, each a
// norm plus three divisions when it must scale), then the end test.
// in_ready is high only while the sequencer is idle.
//
// reset: all control state clears, registers return to their defaults and
// no run is armed. a result waits in the output register while the receiver
// stalls; the next input is taken meanwhile, and a new result is held back
// until the previous one has been transferred.
module slew_limited_gradient_rewinder_core
    import slgr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic signed [31:0]   start_gx,
    input  logic signed [31:0]   start_gy,
    input  logic signed [31:0]   start_gz,
    input  logic signed [31:0]   start_kx,
    input  logic signed [31:0]   start_ky,
    input  logic signed [31:0]   start_kz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   grad_x,
    output logic signed [31:0]   grad_y,
    output logic signed [31:0]   grad_z,
    output logic                 last,
    output logic                 overrun,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_T0   = 6'd1;   // r * max_step
    localparam logic [5:0] S_T1   = 6'd2;   // u * u
    localparam logic [5:0] S_T2   = 6'd3;   // kacc * kacc
    localparam logic [5:0] S_T3   = 6'd4;
    localparam logic [5:0] S_LOOP = 6'd5;
    localparam logic [5:0] S_SQM  = 6'd6;   // square one component
    localparam logic [5:0] S_SQA  = 6'd7;   // accumulate
    localparam logic [5:0] S_SQR  = 6'd8;   // square root iterations
    localparam logic [5:0] S_GS   = 6'd9;
    localparam logic [5:0] S_GS2  = 6'd10;
    localparam logic [5:0] S_KR   = 6'd11;
    localparam logic [5:0] S_KR2  = 6'd12;
    localparam logic [5:0] S_NR   = 6'd13;  // near test entry
    localparam logic [5:0] S_NRC  = 6'd14;
    localparam logic [5:0] S_NEAR = 6'd15;
    localparam logic [5:0] S_RMP  = 6'd16;
    localparam logic [5:0] S_RMPD = 6'd17;
    localparam logic [5:0] S_RMPW = 6'd18;
    localparam logic [5:0] S_CL   = 6'd19;  // clip: shift search
    localparam logic [5:0] S_CLN  = 6'd20;
    localparam logic [5:0] S_CLM  = 6'd21;
    localparam logic [5:0] S_CLD  = 6'd22;
    localparam logic [5:0] S_CLW  = 6'd23;
    localparam logic [5:0] S_FAR2 = 6'd24;
    localparam logic [5:0] S_FAR3 = 6'd25;
    localparam logic [5:0] S_KU   = 6'd26;
    localparam logic [5:0] S_KU2  = 6'd27;
    localparam logic [5:0] S_END0 = 6'd28;
    localparam logic [5:0] S_END1 = 6'd29;
    localparam logic [5:0] S_END2 = 6'd30;
    localparam logic [5:0] S_EMIT = 6'd31;
    localparam logic [5:0] S_DIV  = 6'd32;

    localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(ITER_STEPS - 1);
    localparam logic [FC_W-1:0] FC_MAX  = FC_W'(MAX_FINE_STEPS);

    logic [5:0] state_reg;
    logic [5:0] sq_ret_reg;
    logic [5:0] sub_ret_reg;
    logic [5:0] div_ret_reg;

    // configuration
    logic signed [31:0] tgt_reg [AXES];
    logic [30:0] amp_reg;
    logic [23:0] step_reg;
    logic [6:0]  ratio_reg;
    logic [23:0] coef_reg;

    // run state
    logic signed [31:0] g_reg [AXES];
    logic signed [31:0] k_reg [AXES];
    logic [FC_W-1:0]    fc_reg;
    logic               run_reg;

    // working registers
    logic signed [34:0] diff_reg [AXES];
    logic [47:0]        m_reg [AXES];
    logic               gneg_reg [AXES];
    logic [31:0]        vec_reg [AXES];
    logic [6:0]         r_reg;
    logic [6:0]         i_reg;
    logic [30:0]        u_reg;
    logic [63:0]        tol2_reg;
    logic [31:0]        gn_reg;
    logic [31:0]        s_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        prod_reg;
    logic [AX_W-1:0]    ax_reg;
    logic [IT_W-1:0]    it_reg;
    logic               sq_sqrt_reg;
    logic               near_reg;
    logic               cl_sh_reg;
    logic [30:0]        clip_lim_reg;
    logic               res_last_reg;
    logic               res_over_reg;

    // square root unit
    logic [63:0] sq_x_reg;
    logic [33:0] sq_rem_reg;
    logic [31:0] root_reg;

    // divide unit
    logic [31:0] dv_rem_reg;
    logic [31:0] dv_low_reg;
    logic [31:0] dv_div_reg;
    logic [31:0] q_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_g_reg [3];
    logic               out_last_reg;
    logic               out_over_reg;

    // shared multiplier operands
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] ag;

    assign ag = mag32(g_reg[ax_reg]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T0:
            begin
                mul_a = {25'd0, r_reg};
                mul_b = {8'd0, step_reg};
            end
            S_T1:
            begin
                mul_a = prod_reg[31:0];
                mul_b = prod_reg[31:0];
            end
            S_T2:
            begin
                mul_a = prod_reg[63:32];
                mul_b = prod_reg[63:32];
            end
            S_SQM:
            begin
                mul_a = vec_reg[ax_reg];
                mul_b = vec_reg[ax_reg];
            end
            S_GS:
            begin
                mul_a = {8'd0, coef_reg};
                mul_b = root_reg;
            end
            S_KR:
            begin
                mul_a = ag;
                mul_b = s_reg;
            end
            S_RMP:
            begin
                mul_a = ag;
                mul_b = {8'd0, step_reg};
            end
            S_CLM:
            begin
                mul_a = m_reg[ax_reg][31:0];
                mul_b = {1'b0, clip_lim_reg};
            end
            S_KU:
            begin
                mul_a = ag;
                mul_b = KSTEP_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // square root step, two radicand bits per cycle
    logic [35:0] sq_remsh;
    logic [35:0] sq_trial;
    logic        sq_ge;
    logic [35:0] sq_diff;

    assign sq_remsh = {sq_rem_reg, sq_x_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_remsh >= sq_trial);
    assign sq_diff  = sq_remsh - sq_trial;

    // restoring divide step, one quotient bit per cycle
    logic [32:0] dv_sh;
    logic        dv_ge;
    logic [32:0] dv_diff;

    assign dv_sh   = {dv_rem_reg, dv_low_reg[31]};
    assign dv_ge   = (dv_sh >= {1'b0, dv_div_reg});
    assign dv_diff = dv_sh - {1'b0, dv_div_reg};

    // stopping point prediction for the current axis
    logic signed [33:0] kr_off;
    logic signed [33:0] kr_kret;
    logic signed [34:0] kr_diff;

    always_comb
    begin
        kr_off  = {2'b00, prod_reg[63:32]};
        if (g_reg[ax_reg][31])
        begin
            kr_off = -kr_off;
        end
        kr_kret = {{2{k_reg[ax_reg][31]}}, k_reg[ax_reg]} + kr_off;
        kr_diff = {{3{tgt_reg[ax_reg][31]}}, tgt_reg[ax_reg]} - {kr_kret[33], kr_kret};
    end

    // k advance for the current axis
    logic signed [33:0] ku_off;
    logic signed [33:0] ku_sum;

    always_comb
    begin
        ku_off = {10'd0, prod_reg[63:40]};
        if (g_reg[ax_reg][31])
        begin
            ku_off = -ku_off;
        end
        ku_sum = {{2{k_reg[ax_reg][31]}}, k_reg[ax_reg]} + ku_off;
    end

    // per-axis parallel terms
    logic [47:0]        m_init   [AXES];
    logic [31:0]        diff_mag [AXES];
    logic signed [33:0] far2_val [AXES];
    logic signed [33:0] far3_sum [AXES];
    logic signed [34:0] end_diff [AXES];
    logic               diff_big;
    logic               m_big;

    always_comb
    begin
        logic [34:0]        dm;
        logic signed [33:0] sm;
        diff_big = 1'b0;
        m_big    = 1'b0;
        for (int d = 0; d < AXES; d++)
        begin
            dm = mag35(diff_reg[d]);
            diff_mag[d] = dm[31:0];
            if (dm[34:31] != 4'd0)
            begin
                diff_big = 1'b1;
            end
            // times 5120 as two shifts
            m_init[d] = {1'b0, dm, 12'd0} + {3'd0, dm, 10'd0};
            if (m_reg[d][47:31] != 17'd0)
            begin
                m_big = 1'b1;
            end
            sm = {2'b00, m_reg[d][31:0]};
            if (diff_reg[d][34])
            begin
                sm = -sm;
            end
            far2_val[d] = sm - {{2{g_reg[d][31]}}, g_reg[d]};
            sm = {2'b00, m_reg[d][31:0]};
            if (gneg_reg[d])
            begin
                sm = -sm;
            end
            far3_sum[d] = {{2{g_reg[d][31]}}, g_reg[d]} + sm;
            end_diff[d] = {{3{tgt_reg[d][31]}}, tgt_reg[d]}
                        - {{3{k_reg[d][31]}}, k_reg[d]};
        end
    end

    logic end_done;
    assign end_done = near_reg && (gn_reg < {1'b0, u_reg});

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= 1'b0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
            amp_reg       <= AMP_RESET;
            step_reg      <= STEP_RESET;
            ratio_reg     <= RATIO_RESET;
            coef_reg      <= COEF_RESET;
            for (int d = 0; d < AXES; d++)
            begin
                tgt_reg[d] <= '0;
                g_reg[d]   <= '0;
                k_reg[d]   <= '0;
            end
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TARGET_KX:      tgt_reg[0] <= cfg_data;
                    CFG_TARGET_KY:      if (AXES > 1) tgt_reg[AX_W'(1)] <= cfg_data;
                    CFG_TARGET_KZ:      if (AXES > 2) tgt_reg[AX_W'(2)] <= cfg_data;
                    CFG_MAX_AMPLITUDE:  amp_reg   <= cfg_data[30:0];
                    CFG_MAX_STEP:       step_reg  <= cfg_data[23:0];
                    CFG_OVERSAMPLE:     ratio_reg <= cfg_data[6:0];
                    CFG_LOOKAHEAD_COEF: coef_reg  <= cfg_data[23:0];
                    default:            ;
                endcase
            end

            // the emit state reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (op == OP_START)
                        begin
                            g_reg[0] <= start_gx;
                            k_reg[0] <= start_kx;
                            if (AXES > 1)
                            begin
                                g_reg[AX_W'(1)] <= start_gy;
                                k_reg[AX_W'(1)] <= start_ky;
                            end
                            if (AXES > 2)
                            begin
                                g_reg[AX_W'(2)] <= start_gz;
                                k_reg[AX_W'(2)] <= start_kz;
                            end
                            fc_reg  <= '0;
                            run_reg <= 1'b1;
                        end
                        else if (run_reg)
                        begin
                            r_reg     <= (ratio_reg == 7'd0) ? 7'd1 : ratio_reg;
                            i_reg     <= '0;
                            state_reg <= S_T0;
                        end
                    end
                end
                S_T0:
                begin
                    state_reg <= S_T1;
                end
                S_T1:
                begin
                    u_reg     <= prod_reg[30:0];
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    tol2_reg  <= prod_reg;
                    state_reg <= S_LOOP;
                end
                S_LOOP:
                begin
                    acc_reg     <= '0;
                    ax_reg      <= '0;
                    sq_sqrt_reg <= 1'b1;
                    for (int d = 0; d < AXES; d++)
                    begin
                        vec_reg[d] <= mag32(g_reg[d]);
                    end
                    if ((i_reg < r_reg) && (fc_reg < FC_MAX))
                    begin
                        sq_ret_reg <= S_GS;
                    end
                    else
                    begin
                        sq_ret_reg <= S_END1;
                    end
                    state_reg <= S_SQM;
                end
                S_SQM:
                begin
                    state_reg <= S_SQA;
                end
                S_SQA:
                begin
                    acc_reg <= acc_reg + prod_reg;
                    if (ax_reg == AX_LAST)
                    begin
                        if (sq_sqrt_reg)
                        begin
                            sq_x_reg   <= acc_reg + prod_reg;
                            sq_rem_reg <= '0;
                            root_reg   <= '0;
                            it_reg     <= '0;
                            state_reg  <= S_SQR;
                        end
                        else
                        begin
                            state_reg <= sq_ret_reg;
                        end
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + AX_W'(1);
                        state_reg <= S_SQM;
                    end
                end
                S_SQR:
                begin
                    sq_rem_reg <= sq_ge ? sq_diff[33:0] : sq_remsh[33:0];
                    root_reg   <= {root_reg[30:0], sq_ge};
                    sq_x_reg   <= {sq_x_reg[61:0], 2'b00};
                    it_reg     <= it_reg + IT_W'(1);
                    if (it_reg == IT_LAST)
                    begin
                        state_reg <= sq_ret_reg;
                    end
                end
                S_GS:
                begin
                    gn_reg    <= root_reg;
                    state_reg <= S_GS2;
                end
                S_GS2:
                begin
                    s_reg     <= prod_reg[55:24];
                    ax_reg    <= '0;
                    state_reg <= S_KR;
                end
                S_KR:
                begin
                    state_reg <= S_KR2;
                end
                S_KR2:
                begin
                    diff_reg[ax_reg] <= kr_diff;
                    if (ax_reg == AX_LAST)
                    begin
                        sub_ret_reg <= S_NEAR;
                        state_reg   <= S_NR;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + AX_W'(1);
                        state_reg <= S_KR;
                    end
                end
                S_NR:
                begin
                    // an axis gap of 2^31 or more is never near
                    if (diff_big)
                    begin
                        near_reg  <= 1'b0;
                        state_reg <= sub_ret_reg;
                    end
                    else
                    begin
                        for (int d = 0; d < AXES; d++)
                        begin
                            vec_reg[d] <= diff_mag[d];
                        end
                        acc_reg     <= '0;
                        ax_reg      <= '0;
                        sq_sqrt_reg <= 1'b0;
                        sq_ret_reg  <= S_NRC;
                        state_reg   <= S_SQM;
                    end
                end
                S_NRC:
                begin
                    near_reg  <= (acc_reg < tol2_reg);
                    state_reg <= sub_ret_reg;
                end
                S_NEAR:
                begin
                    ax_reg <= '0;
                    if (near_reg)
                    begin
                        if (gn_reg > {8'd0, step_reg})
                        begin
                            state_reg <= S_RMP;
                        end
                        else
                        begin
                            for (int d = 0; d < AXES; d++)
                            begin
                                g_reg[d] <= '0;
                            end
                            state_reg <= S_KU;
                        end
                    end
                    else
                    begin
                        for (int d = 0; d < AXES; d++)
                        begin
                            m_reg[d] <= m_init[d];
                        end
                        clip_lim_reg <= amp_reg;
                        cl_sh_reg    <= 1'b0;
                        sub_ret_reg  <= S_FAR2;
                        state_reg    <= S_CL;
                    end
                end
                S_RMP:
                begin
                    state_reg <= S_RMPD;
                end
                S_RMPD:
                begin
                    dv_rem_reg  <= prod_reg[63:32];
                    dv_low_reg  <= prod_reg[31:0];
                    dv_div_reg  <= gn_reg;
                    it_reg      <= '0;
                    div_ret_reg <= S_RMPW;
                    state_reg   <= S_DIV;
                end
                S_RMPW:
                begin
                    // ramp down along the gradient's own direction
                    if (g_reg[ax_reg][31])
                    begin
                        g_reg[ax_reg] <= g_reg[ax_reg] + $signed(q_reg);
                    end
                    else
                    begin
                        g_reg[ax_reg] <= g_reg[ax_reg] - $signed(q_reg);
                    end
                    if (ax_reg == AX_LAST)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_KU;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + AX_W'(1);
                        state_reg <= S_RMP;
                    end
                end
                S_CL:
                begin
                    // shift until every component fits below 2^31
                    if (m_big)
                    begin
                        for (int d = 0; d < AXES; d++)
                        begin
                            m_reg[d] <= {1'b0, m_reg[d][47:1]};
                        end
                        cl_sh_reg <= 1'b1;
                    end
                    else
                    begin
                        for (int d = 0; d < AXES; d++)
                        begin
                            vec_reg[d] <= m_reg[d][31:0];
                        end
                        acc_reg     <= '0;
                        ax_reg      <= '0;
                        sq_sqrt_reg <= 1'b1;
                        sq_ret_reg  <= S_CLN;
                        state_reg   <= S_SQM;
                    end
                end
                S_CLN:
                begin
                    ax_reg <= '0;
                    if (cl_sh_reg || (root_reg > {1'b0, clip_lim_reg}))
                    begin
                        state_reg <= S_CLM;
                    end
                    else
                    begin
                        state_reg <= sub_ret_reg;
                    end
                end
                S_CLM:
                begin
                    state_reg <= S_CLD;
                end
                S_CLD:
                begin
                    dv_rem_reg  <= prod_reg[63:32];
                    dv_low_reg  <= prod_reg[31:0];
                    dv_div_reg  <= root_reg;
                    it_reg      <= '0;
                    div_ret_reg <= S_CLW;
                    state_reg   <= S_DIV;
                end
                S_CLW:
                begin
                    m_reg[ax_reg] <= {16'd0, q_reg};
                    if (ax_reg == AX_LAST)
                    begin
                        state_reg <= sub_ret_reg;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + AX_W'(1);
                        state_reg <= S_CLM;
                    end
                end
                S_FAR2:
                begin
                    // gradient change toward the clipped target
                    for (int d = 0; d < AXES; d++)
                    begin
                        gneg_reg[d] <= far2_val[d][33];
                        m_reg[d]    <= {14'd0, mag34(far2_val[d])};
                    end
                    clip_lim_reg <= {7'd0, step_reg};
                    cl_sh_reg    <= 1'b0;
                    sub_ret_reg  <= S_FAR3;
                    state_reg    <= S_CL;
                end
                S_FAR3:
                begin
                    for (int d = 0; d < AXES; d++)
                    begin
                        g_reg[d] <= sat34(far3_sum[d]);
                    end
                    ax_reg    <= '0;
                    state_reg <= S_KU;
                end
                S_KU:
                begin
                    state_reg <= S_KU2;
                end
                S_KU2:
                begin
                    k_reg[ax_reg] <= sat34(ku_sum);
                    if (ax_reg == AX_LAST)
                    begin
                        fc_reg    <= fc_reg + FC_W'(1);
                        i_reg     <= i_reg + 7'd1;
                        state_reg <= S_LOOP;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + AX_W'(1);
                        state_reg <= S_KU;
                    end
                end
                S_END0:
                begin
                    state_reg <= S_END1;
                end
                S_END1:
                begin
                    gn_reg <= root_reg;
                    for (int d = 0; d < AXES; d++)
                    begin
                        diff_reg[d] <= end_diff[d];
                    end
                    sub_ret_reg <= S_END2;
                    state_reg   <= S_NR;
                end
                S_END2:
                begin
                    res_last_reg <= end_done || (fc_reg >= FC_MAX);
                    res_over_reg <= !end_done && (fc_reg >= FC_MAX);
                    if (end_done || (fc_reg >= FC_MAX))
                    begin
                        run_reg <= 1'b0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold until the previous result has been transferred
                    if (!out_valid_reg || out_ready)
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            if (d < AXES)
                            begin
                                out_g_reg[d] <= g_reg[AX_W'(d)];
                            end
                            else
                            begin
                                out_g_reg[d] <= '0;
                            end
                        end
                        out_last_reg  <= res_last_reg;
                        out_over_reg  <= res_over_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    dv_rem_reg <= dv_ge ? dv_diff[31:0] : dv_sh[31:0];
                    dv_low_reg <= {dv_low_reg[30:0], 1'b0};
                    q_reg      <= {q_reg[30:0], dv_ge};
                    it_reg     <= it_reg + IT_W'(1);
                    if (it_reg == IT_LAST)
                    begin
                        state_reg <= div_ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign grad_x    = out_g_reg[0];
    assign grad_y    = out_g_reg[1];
    assign grad_z    = out_g_reg[2];
    assign last      = out_last_reg;
    assign overrun   = out_over_reg;

    // an overrun always ends the run
    a_over_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!overrun || last))
        else $error("overrun without last");

    // a start transfer arms a fresh run
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_START)) |=> (run_reg && (fc_reg == '0)))
        else $error("start did not arm the run");

    // fine step counter stays within the limit
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_MAX)
        else $error("fine step count past limit");

    // clipped components never exceed the clip limit
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLW) |-> (q_reg <= {1'b0, clip_lim_reg}))
        else $error("clip quotient above limit");

endmodule

// ----- test/slew_limited_gradient_rewinder_core_tb.sv -----
module slew_limited_gradient_rewinder_core_tb;
    import slgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint s64;
    typedef longint unsigned u64;

    // one expected output sample
    typedef struct {
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic        last;
        logic        overrun;
    } sample_t;

    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam u64 LIM31 = 64'h8000_0000;
    localparam u64 GAIN_Q8 = 5120;
    // index past the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 op = OP_START;
    logic signed [31:0]   start_gx = '0;
    logic signed [31:0]   start_gy = '0;
    logic signed [31:0]   start_gz = '0;
    logic signed [31:0]   start_kx = '0;
    logic signed [31:0]   start_ky = '0;
    logic signed [31:0]   start_kz = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   grad_x;
    logic signed [31:0]   grad_y;
    logic signed [31:0]   grad_z;
    logic                 last;
    logic                 overrun;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    slew_limited_gradient_rewinder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .start_gx  (start_gx),
        .start_gy  (start_gy),
        .start_gz  (start_gz),
        .start_kx  (start_kx),
        .start_ky  (start_ky),
        .start_kz  (start_kz),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .grad_z    (grad_z),
        .last      (last),
        .overrun   (overrun),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the configuration registers
    s64 tgt_k[3] = '{0, 0, 0};
    u64 amp_limit = 67108864;
    u64 step_limit = 251658;
    u64 ratio_reg = 4;
    u64 coef_reg = 2380990;

    // shadow copy of the rewinder state
    s64 grad_now[3] = '{0, 0, 0};
    s64 kpos_now[3] = '{0, 0, 0};
    int unsigned fine_steps = 0;
    bit run_armed = 1'b0;

    sample_t expected_samples[$];
    int errors = 0;
    bit calm = 1'b0;      // no idling on either side while set
    longint cycles = 0;

    // ------------------------------------------------------------------
    // fixed point helpers
    // ------------------------------------------------------------------
    function automatic u64 magn(s64 a);
        return (a < 0) ? u64'(-a) : u64'(a);
    endfunction

    function automatic s64 sat_word(s64 v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // signed times unsigned on magnitudes, truncated, sign restored
    function automatic s64 scale_shr(s64 a, u64 b, int sh);
        u64 p;
        p = (magn(a) * b) >> sh;
        return (a < 0) ? -s64'(p) : s64'(p);
    endfunction

    function automatic u64 int_sqrt(u64 x);
        u64 r;
        u64 b;
        r = 0;
        b = u64'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic u64 grad_norm();
        u64 s;
        s = 0;
        for (int d = 0; d < AXES; d++) s += magn(grad_now[d]) * magn(grad_now[d]);
        return int_sqrt(s);
    endfunction

    // scale a magnitude vector down to the limit, with pre-shift below 2^31
    function automatic void clip_mags(inout u64 m[3], input u64 lim);
        int sh;
        u64 s;
        u64 n;
        bit big;
        sh = 0;
        s = 0;
        big = 1'b1;
        while (big)
        begin
            big = 1'b0;
            for (int d = 0; d < AXES; d++) if ((m[d] >> sh) >= LIM31) big = 1'b1;
            if (big) sh++;
        end
        for (int d = 0; d < AXES; d++) s += (m[d] >> sh) * (m[d] >> sh);
        n = int_sqrt(s);
        if (sh > 0 || n > lim)
            for (int d = 0; d < AXES; d++) m[d] = ((m[d] >> sh) * lim) / n;
    endfunction

    function automatic bit near_target(s64 p[3], u64 tol);
        u64 s;
        u64 m;
        s = 0;
        for (int d = 0; d < AXES; d++)
        begin
            m = magn(tgt_k[d] - p[d]);
            if (m >= LIM31) return 1'b0;
            s += m * m;
        end
        return s < tol * tol;
    endfunction

    // one fine step of the slew limited steering law
    function automatic void fine_update(u64 kacc);
        s64 kret[3];
        s64 gt[3];
        u64 m[3];
        u64 gn;
        u64 s;
        u64 dl;
        gn = grad_norm();
        s = (coef_reg * gn) >> 24;
        for (int d = 0; d < 3; d++) kret[d] = 0;
        for (int d = 0; d < AXES; d++) kret[d] = kpos_now[d] + scale_shr(grad_now[d], s, 32);
        if (near_target(kret, kacc))
        begin
            // ramp down along the current direction
            for (int d = 0; d < AXES; d++)
            begin
                if (gn > step_limit)
                begin
                    dl = (magn(grad_now[d]) * step_limit) / gn;
                    grad_now[d] = (grad_now[d] < 0) ? grad_now[d] + s64'(dl)
                                                    : grad_now[d] - s64'(dl);
                end
                else
                begin
                    grad_now[d] = 0;
                end
            end
        end
        else
        begin
            // steer toward the clipped target gradient
            for (int d = 0; d < 3; d++) m[d] = 0;
            for (int d = 0; d < AXES; d++) m[d] = magn(tgt_k[d] - kret[d]) * GAIN_Q8;
            clip_mags(m, amp_limit);
            for (int d = 0; d < AXES; d++)
            begin
                gt[d] = (tgt_k[d] < kret[d]) ? -s64'(m[d]) : s64'(m[d]);
                gt[d] = gt[d] - grad_now[d];
                m[d] = magn(gt[d]);
            end
            clip_mags(m, step_limit);
            for (int d = 0; d < AXES; d++)
                grad_now[d] = sat_word(grad_now[d] + ((gt[d] < 0) ? -s64'(m[d]) : s64'(m[d])));
        end
        for (int d = 0; d < AXES; d++)
            kpos_now[d] = sat_word(kpos_now[d] + scale_shr(grad_now[d], u64'(KSTEP_Q32), 40));
    endfunction

    // advance the shadow state by one accepted transfer; 1 if a sample follows
    function automatic bit predict_rewinder(logic o, logic signed [31:0] v[6],
                                            output sample_t smp);
        u64 rr;
        u64 u;
        u64 kacc;
        u64 gn;
        bit done;
        bit over;
        smp = '{default: '0};
        if (o == OP_START)
        begin
            for (int d = 0; d < 3; d++)
            begin
                grad_now[d] = (d < AXES) ? s64'(v[d]) : 0;
                kpos_now[d] = (d < AXES) ? s64'(v[3 + d]) : 0;
            end
            fine_steps = 0;
            run_armed = 1'b1;
            return 1'b0;
        end
        if (!run_armed) return 1'b0;
        rr = (ratio_reg == 0) ? 1 : ratio_reg;
        u = rr * step_limit;
        kacc = (u * u) >> 32;
        for (u64 i = 0; i < rr && fine_steps < MAX_FINE_STEPS; i++)
        begin
            fine_update(kacc);
            fine_steps++;
        end
        gn = grad_norm();
        done = near_target(kpos_now, kacc) && gn < u;
        over = !done && fine_steps >= MAX_FINE_STEPS;
        if (done || over) run_armed = 1'b0;
        smp.gx = grad_now[0][31:0];
        smp.gy = grad_now[1][31:0];
        smp.gz = grad_now[2][31:0];
        smp.last = done || over;
        smp.overrun = over;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t unexpected sample: expected none actual %h %h %h %b %b",
                         $time, grad_x, grad_y, grad_z, last, overrun);
                errors++;
            end
            else
            begin
                e = expected_samples.pop_front();
                check_field("grad_x", e.gx, grad_x);
                check_field("grad_y", e.gy, grad_y);
                check_field("grad_z", e.gz, grad_z);
                check_field("last", {31'd0, e.last}, {31'd0, last});
                check_field("overrun", {31'd0, e.overrun}, {31'd0, overrun});
            end
        end
        // receiver stalls in about a fifth of the cycles
        out_ready <= calm || ($urandom_range(99) >= 21);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // drop in_valid once the last transfer has gone
    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one input transfer; valid stays high into the next item unless a gap is drawn
    task automatic send_item(logic o, logic signed [31:0] v[6]);
        sample_t smp;
        if (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (!calm && $urandom_range(99) < 21);
        end
        in_valid <= 1'b1;
        op <= o;
        start_gx <= v[0];
        start_gy <= v[1];
        start_gz <= v[2];
        start_kx <= v[3];
        start_ky <= v[4];
        start_kz <= v[5];
        do @(posedge clk); while (!in_ready);
        if (predict_rewinder(o, v, smp)) expected_samples.push_back(smp);
    endtask

    task automatic send_start(logic signed [31:0] gx, gy, gz, kx, ky, kz);
        logic signed [31:0] v[6];
        v = '{gx, gy, gz, kx, ky, kz};
        send_item(OP_START, v);
    endtask

    // ticks carry junk in the start fields, which must be ignored
    task automatic send_ticks(int n);
        logic signed [31:0] v[6];
        for (int i = 0; i < n; i++)
        begin
            foreach (v[j]) v[j] = $urandom;
            send_item(OP_TICK, v);
        end
    endtask

    // wait for all samples and an idle sequencer before touching registers
    task automatic settle();
        go_idle();
        while (expected_samples.size() != 0 || !in_ready) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TARGET_KX:      tgt_k[0] = s64'(signed'(data));
            CFG_TARGET_KY:      tgt_k[1] = s64'(signed'(data));
            CFG_TARGET_KZ:      tgt_k[2] = s64'(signed'(data));
            CFG_MAX_AMPLITUDE:  amp_limit = u64'(data[30:0]);
            CFG_MAX_STEP:       step_limit = u64'(data[23:0]);
            CFG_OVERSAMPLE:     ratio_reg = u64'(data[6:0]);
            CFG_LOOKAHEAD_COEF: coef_reg = u64'(data[23:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_word(int kind);
        case (kind)
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(4, 12);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // defaults: tick while idle, trivial run at the target, then a run from a nonzero gradient
    task automatic test_defaults();
        send_ticks(2);
        send_start(0, 0, 0, 0, 0, 0);
        send_ticks(2);
        send_start(32'sd503316, -32'sd503316, 32'sd100000, 0, 0, 0);
        send_ticks(6);
        settle();
    endtask

    // saturating vectors and registers, a restart in the middle of a run, then zero limits
    task automatic test_extremes();
        write_reg(CFG_LOOKAHEAD_COEF, 32'hffff_ffff);
        write_reg(CFG_MAX_AMPLITUDE, 32'h7fff_ffff);
        write_reg(CFG_MAX_STEP, 32'h00ff_ffff);
        send_start(32'sh7fff_ffff, 32'sh8000_0000, 0,
                   32'sh8000_0000, 32'sh7fff_ffff, 0);
        send_ticks(3);
        send_start(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        send_ticks(3);
        settle();
        write_reg(CFG_LOOKAHEAD_COEF, 0);
        write_reg(CFG_MAX_AMPLITUDE, 0);
        write_reg(CFG_MAX_STEP, 1);
        send_start(32'sd1000, -32'sd1000, 32'sd3, 32'sd70000, 0, -32'sd70000);
        send_ticks(3);
        settle();
    endtask

    // ratio of zero acts as one, out-of-range index is dropped
    task automatic test_ratio_and_index();
        write_reg(CFG_IDX_NONE, 32'hdead_beef);
        write_reg(CFG_OVERSAMPLE, 32'hffff_ff80);
        write_reg(CFG_MAX_STEP, 32'd251658);
        write_reg(CFG_MAX_AMPLITUDE, 32'd67108864);
        write_reg(CFG_LOOKAHEAD_COEF, 32'd2380990);
        write_reg(CFG_TARGET_KX, 32'd65536);
        write_reg(CFG_TARGET_KY, -32'sd32768);
        write_reg(CFG_TARGET_KZ, 32'd1000);
        send_start(32'sd1677722, 0, -32'sd838861, 0, 0, 0);
        send_ticks(5);
        settle();
    endtask

    // run into the fine step limit; a tick stops part way, the tick after it finds no run
    task automatic test_overrun();
        write_reg(CFG_OVERSAMPLE, 32'd60);
        write_reg(CFG_MAX_AMPLITUDE, 32'd16777216);
        write_reg(CFG_TARGET_KX, 32'h4000_0000);
        write_reg(CFG_TARGET_KY, 0);
        write_reg(CFG_TARGET_KZ, 0);
        calm = 1'b1;
        send_start(0, 0, 0, 0, 0, 0);
        send_ticks(69);
        calm = 1'b0;
        send_ticks(1);
        settle();
    endtask

    task automatic random_config();
        logic [31:0] t;
        for (int d = 0; d < 3; d++)
        begin
            t = ($urandom_range(3) == 0) ? $urandom : ($signed($urandom) >>> 12);
            write_reg(CFG_IDX_W'(CFG_TARGET_KX + d), t);
        end
        case ($urandom_range(3))
            0: t = 32'h7fff_ffff;
            1: t = {1'($urandom_range(1)), 31'd0};
            default: t = $urandom;
        endcase
        write_reg(CFG_MAX_AMPLITUDE, t);
        case ($urandom_range(4))
            0: t = {8'($urandom_range(255)), 24'd1};
            1: t = 32'h00ff_ffff;
            2: t = $urandom;
            default: t = $urandom_range(20000, 600000);
        endcase
        write_reg(CFG_MAX_STEP, t);
        case ($urandom_range(9))
            0: t = {25'($urandom), 7'd0};
            1: t = {8'($urandom_range(255)), 24'd0} | 32'($urandom_range(0, 127));
            default: t = $urandom_range(1, 4);
        endcase
        write_reg(CFG_OVERSAMPLE, t);
        t = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 4000000);
        write_reg(CFG_LOOKAHEAD_COEF, t);
        if ($urandom_range(3) == 0) write_reg(CFG_IDX_NONE, $urandom);
    endtask

    // phases of random runs, mostly well-formed start-then-ticks sequences
    task automatic test_random(int total);
        int sent;
        int budget;
        int n;
        logic signed [31:0] v[6];
        sent = 0;
        while (sent < total)
        begin
            random_config();
            calm = ($urandom_range(7) == 0);
            // long ratios are slow, keep those phases short
            budget = (ratio_reg > 8) ? 6 : 40;
            while (budget > 0)
            begin
                if ($urandom_range(99) < 85)
                begin
                    for (int d = 0; d < 3; d++)
                    begin
                        v[d] = rand_word(($urandom_range(4) == 0) ? $urandom_range(2) : 3);
                        v[3 + d] = ($urandom_range(3) == 0)
                                 ? rand_word($urandom_range(2))
                                 : 32'(tgt_k[d]) + ($signed($urandom) >>> $urandom_range(10, 24));
                    end
                    send_item(OP_START, v);
                    n = (ratio_reg > 8) ? $urandom_range(1, 3) : $urandom_range(1, 15);
                    send_ticks(n);
                    sent += n + 1;
                    budget -= n + 1;
                end
                else
                begin
                    // noise: lone ticks or back to back starts
                    foreach (v[j]) v[j] = $urandom;
                    send_item(1'($urandom_range(1)), v);
                    sent++;
                    budget--;
                end
            end
            settle();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_ratio_and_index();
        test_overrun();
        test_random(1350);
        settle();
        repeat (2000) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/slgr_pkg.sv
design/slew_limited_gradient_rewinder_core.sv
test/slew_limited_gradient_rewinder_core_tb.sv
